// ----- hw/rtl/at_urc_pkg.sv -----
`timescale 1ns / 1ps
package at_urc_pkg;

  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;
  localparam logic [7:0]  CH_QUOTE = 8'h22;

  localparam logic        ACT_BYTE = 1'b0;
  localparam logic        ACT_TICK = 1'b1;

  localparam logic        KIND_BYTE  = 1'b0;
  localparam logic        KIND_ABORT = 1'b1;

  localparam logic [1:0]  HUNT_NONE = 2'd0;
  localparam logic [1:0]  HUNT_CR   = 2'd1;
  localparam logic [1:0]  HUNT_LF   = 2'd2;

  localparam int          PADDR_W   = 3;
  localparam logic        REG_TIMEOUT = 1'b0;
  localparam logic        REG_MAX_LEN = 1'b1;

  localparam logic [7:0]  TIMEOUT_RESET = 8'd5;
  localparam logic [11:0] MAX_LEN_RESET = 12'd2048;
  localparam logic [11:0] MIN_LEN       = 12'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_byte;
    logic       first;
    logic       last;
  } word_t;

  typedef struct packed {
    logic  valid;
    logic  start;
    word_t word;
  } step_res_t;

endpackage

// ----- hw/rtl/at_urc_if.sv -----
`timescale 1ns / 1ps
interface at_urc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface at_urc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] frame_byte;
  logic       first;
  logic       last;

  modport source (output valid, output kind, output frame_byte, output first,
                  output last, input ready);
  modport sink   (input valid, input kind, input frame_byte, input first,
                  input last, output ready);
endinterface

// ----- hw/rtl/at_urc_line_framer_unit.sv -----
`timescale 1ns / 1ps
// Line framer for unsolicited modem result lines. Takes one word per cycle
// (a received byte or a timer tick) while the output accepts, and delivers
// frame bytes, starting at the CR LF '+' that opens a line and ending with
// the LF of the first CR LF outside quotes, or a single abort word on timeout
// or overlength. Each input word is processed in the cycle it is accepted and
// its result is held in a one-word output register, so input and output run at
// one word per cycle while out_ch.ready is high. The only exception is the
// start of a frame: its three opening bytes leave the output register one
// after another, and input is held while the first two of them wait.
// Configuration: timeout_ticks at byte address 0, max_length at address 4.
module at_urc_line_framer_unit (
  input  logic                          clk,
  input  logic                          rst,
  at_urc_in_if.sink                     in_ch,
  at_urc_out_if.source                  out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [at_urc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import at_urc_pkg::*;

  logic [7:0]  timeout_ticks;
  logic [11:0] max_length;
  step_res_t   res;
  logic        in_accept;
  logic        out_take;
  logic        out_valid;
  word_t       out_word;
  logic [1:0]  pend;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_length    <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TIMEOUT) begin
        timeout_ticks <= pwdata[7:0];
      end else begin
        max_length <= pwdata[11:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TIMEOUT: prdata = {24'd0, timeout_ticks};
      REG_MAX_LEN: prdata = {20'd0, max_length};
      default:     prdata = '0;
    endcase
  end

  assign out_take    = out_valid && out_ch.ready;
  assign in_ch.ready = !out_valid || (out_ch.ready && pend == 2'd0);
  assign in_accept   = in_ch.valid && in_ch.ready;

  at_urc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .action        (in_ch.action),
    .rx_byte       (in_ch.rx_byte),
    .timeout_ticks (timeout_ticks),
    .max_length    (max_length),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 2'd0;
    end else if (in_accept && res.valid) begin
      out_valid <= 1'b1;
      pend      <= res.start ? 2'd2 : 2'd0;
    end else if (out_take) begin
      if (pend != 2'd0) begin
        pend <= pend - 2'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res.valid) begin
      out_word <= res.word;
    end else if (out_take && pend != 2'd0) begin
      out_word.kind       <= KIND_BYTE;
      out_word.frame_byte <= (pend == 2'd2) ? CH_LF : CH_PLUS;
      out_word.first      <= 1'b0;
      out_word.last       <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.kind       = out_word.kind;
  assign out_ch.frame_byte = out_word.frame_byte;
  assign out_ch.first      = out_word.first;
  assign out_ch.last       = out_word.last;

endmodule

// ----- hw/rtl/at_urc_core.sv -----
`timescale 1ns / 1ps
module at_urc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  action,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            timeout_ticks,
  input  logic [11:0]           max_length,
  output at_urc_pkg::step_res_t res
);
  import at_urc_pkg::*;

  logic [1:0]  hunt_stage, hunt_stage_next;
  logic        in_frame, in_frame_next;
  logic        in_quote, in_quote_next;
  logic        prev_was_cr, prev_was_cr_next;
  logic [11:0] frame_length, frame_length_next;
  logic [7:0]  idle_ticks, idle_ticks_next;

  logic [7:0]  tmo;
  logic [11:0] lim;
  logic [7:0]  idle_inc;
  logic        quote_new;

  assign tmo       = (timeout_ticks == 8'd0) ? 8'd1 : timeout_ticks;
  assign lim       = (max_length < MIN_LEN) ? MIN_LEN : max_length;
  assign idle_inc  = (idle_ticks == 8'hFF) ? idle_ticks : idle_ticks + 8'd1;
  assign quote_new = (rx_byte == CH_QUOTE) ? ~in_quote : in_quote;

  always_comb begin
    hunt_stage_next   = hunt_stage;
    in_frame_next     = in_frame;
    in_quote_next     = in_quote;
    prev_was_cr_next  = prev_was_cr;
    frame_length_next = frame_length;
    idle_ticks_next   = idle_ticks;
    res               = '0;
    if (action == ACT_TICK) begin
      if (in_frame || hunt_stage != HUNT_NONE) begin
        idle_ticks_next = idle_inc;
        if (idle_inc >= tmo) begin
          hunt_stage_next   = HUNT_NONE;
          in_frame_next     = 1'b0;
          in_quote_next     = 1'b0;
          prev_was_cr_next  = 1'b0;
          frame_length_next = '0;
          idle_ticks_next   = '0;
          if (in_frame) begin
            res.valid     = 1'b1;
            res.word.kind = KIND_ABORT;
          end
        end
      end
    end else begin
      idle_ticks_next = '0;
      if (!in_frame) begin
        if (hunt_stage == HUNT_LF && rx_byte == CH_PLUS) begin
          hunt_stage_next   = HUNT_NONE;
          in_frame_next     = 1'b1;
          in_quote_next     = 1'b0;
          prev_was_cr_next  = 1'b0;
          frame_length_next = MIN_LEN;
          res.valid         = 1'b1;
          res.start         = 1'b1;
          res.word.kind     = KIND_BYTE;
          res.word.frame_byte = CH_CR;
          res.word.first    = 1'b1;
        end else if (hunt_stage == HUNT_CR && rx_byte == CH_LF) begin
          hunt_stage_next = HUNT_LF;
        end else if (rx_byte == CH_CR) begin
          hunt_stage_next = HUNT_CR;
        end else begin
          hunt_stage_next = HUNT_NONE;
        end
      end else if (frame_length >= lim) begin
        hunt_stage_next   = HUNT_NONE;
        in_frame_next     = 1'b0;
        in_quote_next     = 1'b0;
        prev_was_cr_next  = 1'b0;
        frame_length_next = '0;
        res.valid         = 1'b1;
        res.word.kind     = KIND_ABORT;
      end else begin
        res.valid           = 1'b1;
        res.word.kind       = KIND_BYTE;
        res.word.frame_byte = rx_byte;
        if (rx_byte == CH_LF && prev_was_cr && !quote_new) begin
          hunt_stage_next   = HUNT_NONE;
          in_frame_next     = 1'b0;
          in_quote_next     = 1'b0;
          prev_was_cr_next  = 1'b0;
          frame_length_next = '0;
          res.word.last     = 1'b1;
        end else begin
          frame_length_next = frame_length + 12'd1;
          in_quote_next     = quote_new;
          prev_was_cr_next  = (rx_byte == CH_CR);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_stage   <= HUNT_NONE;
      in_frame     <= 1'b0;
      in_quote     <= 1'b0;
      prev_was_cr  <= 1'b0;
      frame_length <= '0;
      idle_ticks   <= '0;
    end else if (accept) begin
      hunt_stage   <= hunt_stage_next;
      in_frame     <= in_frame_next;
      in_quote     <= in_quote_next;
      prev_was_cr  <= prev_was_cr_next;
      frame_length <= frame_length_next;
      idle_ticks   <= idle_ticks_next;
    end
  end

endmodule
